// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// lbl: property prop must hold at every rising edge of clk_i
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// lbl: expr must never be true
`define CHK_NEVER(lbl, expr, msg) \
  `CHK_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/bsps_pkg.sv =====
// ----------------------------------------------------------------------------
// bsps_pkg
// Shared constants, types and states of the beat slice playback sequencer.
// ----------------------------------------------------------------------------
package bsps_pkg;

  localparam int unsigned FRAME_BITS = 20;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned MAX_SEG    = 256;
  localparam int unsigned SEG_BITS   = $clog2(MAX_SEG);
  localparam int unsigned CNT_W      = SEG_BITS + 1;
  localparam int unsigned FR_W       = FRAME_BITS + 1;
  localparam int unsigned OFF_W      = FRAME_BITS;
  localparam int unsigned POS_W      = FRAME_BITS + FRAC_BITS;
  localparam int unsigned PH_W       = POS_W + 1;
  localparam int unsigned DIV_W      = PH_W;
  localparam int unsigned DIV_CW     = $clog2(DIV_W);
  localparam int unsigned REM2_W     = CNT_W + 1;
  localparam int unsigned Q16_W      = 17;
  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic CFG_FRAMES = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef enum logic [3:0] {
    S_RB_KICK, S_RB_DIV, S_RB_FILL, S_RB_RD1, S_RB_BND,
    S_IDLE, S_WITHIN, S_CALC, S_IDX, S_SST, S_NXT, S_BND,
    S_STUT, S_GMOD, S_OUT
  } seq_state_e;

  typedef struct packed {
    logic                fill_start;
    logic [OFF_W-1:0]    step_q;
    logic [REM2_W-1:0]   step_r;
    logic [CNT_W-1:0]    count;
    logic [SEG_BITS-1:0] rd_addr;
  } offs_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/bsps_div.sv =====
// ----------------------------------------------------------------------------
// bsps_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsps_div
  import bsps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output div_stat_t        stat_o,
  output logic [DIV_W-1:0] quo_o,
  output logic [DIV_W-1:0] rem_o
);

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_W-1:0]  num_q, den_q, quo_q, rem_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              take;

  assign trial = {rem_q, num_q[DIV_W-1]};
  assign take  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], take};
      rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

// ===== rtl/bsps_offsets.sv =====
// ----------------------------------------------------------------------------
// bsps_offsets
// Segment offset table: incremental rounded fill, one entry per cycle.
// ----------------------------------------------------------------------------
module bsps_offsets
  import bsps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  offs_req_t        req_i,
  output logic             fill_done_o,
  output logic [OFF_W-1:0] rd_data_o
);

  logic [OFF_W-1:0]  mem [MAX_SEG];
  logic              active_q, done_q;
  logic [CNT_W-1:0]  idx_q, cnt_q;
  logic [OFF_W-1:0]  off_q, stq_q;
  logic [REM2_W-1:0] rem_q, str_q;
  logic [REM2_W:0]   sum;
  logic [REM2_W:0]   two_c;
  logic [OFF_W-1:0]  rd_q;

  assign sum   = {1'b0, rem_q} + {1'b0, str_q};
  assign two_c = {1'b0, cnt_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
    end else if (req_i.fill_start) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      idx_q    <= '0;
    end else if (active_q) begin
      idx_q <= idx_q + 1'b1;
      if (idx_q == cnt_q - 1'b1) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.fill_start) begin
      off_q <= '0;
      rem_q <= REM2_W'(req_i.count);
      stq_q <= req_i.step_q;
      str_q <= req_i.step_r;
      cnt_q <= req_i.count;
    end else if (active_q) begin
      mem[idx_q[SEG_BITS-1:0]] <= off_q;
      if (sum >= two_c) begin
        rem_q <= REM2_W'(sum - two_c);
        off_q <= off_q + stq_q + 1'b1;
      end else begin
        rem_q <= sum[REM2_W-1:0];
        off_q <= off_q + stq_q;
      end
    end
    rd_q <= mem[req_i.rd_addr];
  end

  assign fill_done_o = done_q;
  assign rd_data_o   = rd_q;

endmodule

// ===== rtl/beat_slice_playback_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// beat_slice_playback_sequencer_core
// Per-frame slice sequencer: read position and gate from phase, jumps, stutter.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | word
//  s_axis   | in  | s_axis_tvalid/tready   | frame controls and draws (tdata)
//  m_axis   | out | m_axis_tvalid/tready   | read position (tdata), gate (tuser)
//  cfg      | in  | cfg_we_i               | buffer_frames / segments_in_use
//
// One word at a time: s_axis_tready is high only in idle, so each word takes one
// to five passes of the serial divider (loop position, segment index, next index,
// stutter length, phase wrap) plus accept, sound, table read and output steps.
// After reset or a config write the offset table is rebuilt with one divide plus
// a fill of one entry per cycle; s_axis_tready stays low.
// A stalled m_axis holds the word; the next word waits in the sequencer.
// ----------------------------------------------------------------------------
module beat_slice_playback_sequencer_core
  import bsps_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rate_step, jump_chance, stutter_chance, repeat_count, duty_fraction,
  // draw_jump, draw_stutter, draw_target, zero pad
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_position, zero pad
  output logic [39:0]  m_axis_tdata,
  // audible
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [FR_W-1:0] cfg_data_i
);

  seq_state_e state_q, state_d;

  logic [FR_W-1:0]  frames_cfg_q;
  logic [CNT_W-1:0] count_cfg_q;
  logic [FR_W-1:0]  frames;
  logic [CNT_W-1:0] count;

  logic [PH_W-1:0]     gp_q, sp_q;
  logic [SEG_BITS-1:0] sn_q;
  logic [OFF_W-1:0]    start_q, loop_q, seg_q;
  logic [FR_W-1:0]     bnd_q;
  logic [Q16_W-1:0]    gate_q;
  logic [POS_W-1:0]    within_q;

  logic [19:0] rate_q;
  logic [16:0] jc_q, sc_q, duty_q;
  logic [6:0]  rc_q;
  logic [15:0] dj_q, ds_q, dt_q;

  logic [POS_W-1:0] res_pos_q;
  logic             res_aud_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_aud_q, out_vld_q;

  logic             div_start;
  logic [DIV_W-1:0] div_num, div_den, div_quo, div_rem;
  div_stat_t        div_stat;
  offs_req_t        offs_req;
  logic             fill_done;
  logic [OFF_W-1:0] rd_data;

  logic             accept, out_load;
  logic [PH_W-1:0]  gp_new, sp_new;
  logic             sound, crossed, jump, stut;
  logic [PH_W-1:0]  gate_prod;
  logic [24:0]      tgt_prod;
  logic [CNT_W-1:0] tgt;
  logic [6:0]       rc_eff;
  logic [POS_W-1:0] pos_sum;

  always_comb begin
    frames = frames_cfg_q;
    if (frames_cfg_q < FR_W'(2)) frames = FR_W'(2);
    if (frames_cfg_q > FR_W'(1 << FRAME_BITS)) frames = FR_W'(1 << FRAME_BITS);
    count = count_cfg_q;
    if (count_cfg_q < CNT_W'(2)) count = CNT_W'(2);
    if (count_cfg_q > CNT_W'(MAX_SEG)) count = CNT_W'(MAX_SEG);
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == S_OUT) && (!out_vld_q || m_axis_tready);
  assign gp_new    = gp_q + PH_W'(rate_q);
  assign sp_new    = sp_q + PH_W'(rate_q);
  assign gate_prod = PH_W'(gate_q) * PH_W'(loop_q);
  assign sound     = gate_q[Q16_W-1] || ({1'b0, within_q} < gate_prod);
  assign pos_sum   = {start_q, {FRAC_BITS{1'b0}}} + within_q;
  assign crossed   = gp_new >= {bnd_q, {FRAC_BITS{1'b0}}};
  assign jump      = {1'b0, dj_q} < jc_q;
  assign stut      = {1'b0, ds_q} < sc_q;
  assign tgt_prod  = dt_q * 25'(count);
  assign tgt       = (tgt_prod[24:16] >= count) ? count - 1'b1 : tgt_prod[24:16];
  assign rc_eff    = (rc_q == '0) ? 7'd1 : rc_q;

  always_comb begin
    state_d          = state_q;
    s_axis_tready    = 1'b0;
    div_start        = 1'b0;
    div_num          = '0;
    div_den          = '0;
    offs_req         = '0;
    offs_req.count   = count;
    offs_req.step_q  = div_quo[OFF_W-1:0];
    offs_req.step_r  = {div_rem[CNT_W-1:0], 1'b0};
    unique case (state_q)
      S_RB_KICK: begin
        div_start = 1'b1;
        div_num   = DIV_W'(frames);
        div_den   = DIV_W'(count);
        state_d   = S_RB_DIV;
      end
      S_RB_DIV: begin
        if (div_stat.done) begin
          offs_req.fill_start = 1'b1;
          state_d             = S_RB_FILL;
        end
      end
      S_RB_FILL: if (fill_done) state_d = S_RB_RD1;
      S_RB_RD1: begin
        offs_req.rd_addr = SEG_BITS'(1);
        state_d          = S_RB_BND;
      end
      S_RB_BND: state_d = S_IDLE;
      S_IDLE: begin
        s_axis_tready = !cfg_we_i;
        if (accept) begin
          if (loop_q != '0) begin
            div_start = 1'b1;
            div_num   = sp_q;
            div_den   = {1'b0, loop_q, {FRAC_BITS{1'b0}}};
            state_d   = S_WITHIN;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      S_WITHIN: if (div_stat.done) state_d = S_CALC;
      S_CALC: begin
        div_start = 1'b1;
        if (crossed) begin
          div_num = DIV_W'(sn_q) + 1'b1;
          div_den = DIV_W'(count);
          state_d = S_IDX;
        end else begin
          div_num = gp_new;
          div_den = {frames, {FRAC_BITS{1'b0}}};
          state_d = S_GMOD;
        end
      end
      S_IDX: begin
        if (div_stat.done) begin
          offs_req.rd_addr = jump ? tgt[SEG_BITS-1:0] : div_rem[SEG_BITS-1:0];
          div_start        = 1'b1;
          div_num          = DIV_W'(div_rem[CNT_W-1:0]) + 1'b1;
          div_den          = DIV_W'(count);
          state_d          = S_SST;
        end
      end
      S_SST: state_d = S_NXT;
      S_NXT: begin
        if (div_stat.done) begin
          offs_req.rd_addr = div_rem[SEG_BITS-1:0];
          state_d          = S_BND;
        end
      end
      S_BND: begin
        div_start = 1'b1;
        if (stut) begin
          div_num = DIV_W'(seg_q);
          div_den = DIV_W'(rc_eff);
          state_d = S_STUT;
        end else begin
          div_num = gp_q;
          div_den = {frames, {FRAC_BITS{1'b0}}};
          state_d = S_GMOD;
        end
      end
      S_STUT: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_num   = gp_q;
          div_den   = {frames, {FRAC_BITS{1'b0}}};
          state_d   = S_GMOD;
        end
      end
      S_GMOD: if (div_stat.done) state_d = S_OUT;
      S_OUT: if (out_load) state_d = S_IDLE;
      default: state_d = S_RB_KICK;
    endcase
    if (cfg_we_i) state_d = S_RB_KICK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_RB_KICK;
      frames_cfg_q <= FR_W'(65536);
      count_cfg_q  <= CNT_W'(8);
      gp_q         <= '0;
      sp_q         <= '0;
      sn_q         <= '0;
      start_q      <= '0;
      loop_q       <= '0;
      seg_q        <= '0;
      bnd_q        <= '0;
      gate_q       <= ONE_Q16;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAMES) frames_cfg_q <= cfg_data_i;
        else count_cfg_q <= cfg_data_i[CNT_W-1:0];
      end
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      unique case (state_q)
        S_RB_DIV: begin
          if (div_stat.done) begin
            seg_q  <= div_quo[OFF_W-1:0];
            loop_q <= div_quo[OFF_W-1:0];
          end
        end
        S_RB_BND: begin
          bnd_q   <= FR_W'(rd_data);
          start_q <= '0;
        end
        S_CALC: begin
          gp_q <= gp_new;
          sp_q <= sp_new;
        end
        S_IDX: begin
          if (div_stat.done) begin
            sn_q   <= div_rem[SEG_BITS-1:0];
            sp_q   <= '0;
            gate_q <= (duty_q > ONE_Q16) ? ONE_Q16 : duty_q;
          end
        end
        S_SST: start_q <= rd_data;
        S_BND: begin
          bnd_q <= (rd_data == '0) ? frames : FR_W'(rd_data);
          if (!stut) loop_q <= seg_q;
        end
        S_STUT: if (div_stat.done) loop_q <= div_quo[OFF_W-1:0];
        S_GMOD: if (div_stat.done) gp_q <= div_rem;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rate_q <= s_axis_tdata[19:0];
      jc_q   <= s_axis_tdata[36:20];
      sc_q   <= s_axis_tdata[53:37];
      rc_q   <= s_axis_tdata[60:54];
      duty_q <= s_axis_tdata[77:61];
      dj_q   <= s_axis_tdata[93:78];
      ds_q   <= s_axis_tdata[109:94];
      dt_q   <= s_axis_tdata[125:110];
      if (loop_q == '0) within_q <= '0;
    end
    if (state_q == S_WITHIN && div_stat.done) within_q <= div_rem[POS_W-1:0];
    if (state_q == S_CALC) begin
      res_pos_q <= sound ? pos_sum : '0;
      res_aud_q <= sound;
    end
    if (out_load) begin
      out_pos_q <= res_pos_q;
      out_aud_q <= res_aud_q;
    end
  end

  bsps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  bsps_offsets u_offsets (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (offs_req),
    .fill_done_o (fill_done),
    .rd_data_o   (rd_data)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_pos_q};
  assign m_axis_tuser  = out_aud_q;

`include "assert_macros.svh"

  `CHK_ASSERT(a_one_word_at_a_time, accept |=> !s_axis_tready, "second word taken while busy")
  `CHK_ASSERT(a_cfg_rebuilds, cfg_we_i |=> (state_q == S_RB_KICK) && !s_axis_tready, "config write did not start rebuild")
  `CHK_NEVER(a_gate_range, gate_q > ONE_Q16, "gate fraction above full duty")

endmodule
